/* hdl/ssr_pkg.sv */
// Shared widths and types for the stable score ranker.
package ssr_pkg;

    localparam int SCORE_W = 32;  // input score and max_plus_one width
    localparam int IDX_W   = 5;   // entry_index and max_index port width
    localparam int RANK_W  = 6;   // rank and ranked_count port width

    // Status bits of one cell's stored entry; these move with the entry on unload.
    typedef struct packed {
        logic occ;     // cell holds an entry of the current row
        logic ranked;  // entry's score was non-negative
    } t_ssr_flags;

endpackage

/* hdl/ssr_cell.sv */
// One ranking cell: stores one entry, ranks passing tokens, shifts out on unload.
module ssr_cell #(
    parameter int CW = 6
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_shift,
    input  logic                                  i_tok_vld,
    input  logic signed [ssr_pkg::SCORE_W-1:0]    i_tok_score,
    input  logic [CW-1:0]                         i_tok_cnt,
    input  logic [CW-1:0]                         i_tok_base,
    output logic                                  o_tok_vld,
    output logic signed [ssr_pkg::SCORE_W-1:0]    o_tok_score,
    output logic [CW-1:0]                         o_tok_cnt,
    output logic [CW-1:0]                         o_tok_base,
    input  ssr_pkg::t_ssr_flags                   i_nb_flags,
    input  logic [CW-1:0]                         i_nb_rank,
    output ssr_pkg::t_ssr_flags                   o_flags,
    output logic [CW-1:0]                         o_rank
);

    ssr_pkg::t_ssr_flags                   r_flags;
    logic [CW-1:0]                         r_rank;
    logic signed [ssr_pkg::SCORE_W-1:0]    r_score;
    logic                                  r_tok_vld;
    logic signed [ssr_pkg::SCORE_W-1:0]    r_tok_score;
    logic [CW-1:0]                         r_tok_cnt;
    logic [CW-1:0]                         r_tok_base;
    logic                                  w_tok_ranked;
    logic                                  w_hit;

    assign w_tok_ranked = !i_tok_score[ssr_pkg::SCORE_W-1];
    // a ranked newcomer below this entry pushes this entry's rank up
    assign w_hit = i_tok_vld && r_flags.occ && w_tok_ranked && (i_tok_score < r_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags   <= '0;
            r_tok_vld <= 1'b0;
        end else if (i_shift) begin
            r_flags   <= i_nb_flags;
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= i_tok_vld && r_flags.occ;
            if (i_tok_vld && !r_flags.occ) begin
                r_flags.occ    <= 1'b1;
                r_flags.ranked <= w_tok_ranked;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rank <= i_nb_rank;
        end else if (i_tok_vld) begin
            if (r_flags.occ) begin
                if (w_hit) begin
                    r_rank <= r_rank + CW'(1);
                end
            end else begin
                r_score <= i_tok_score;
                r_rank  <= w_tok_ranked ? (i_tok_base - i_tok_cnt) : '0;
            end
        end
        r_tok_score <= i_tok_score;
        r_tok_cnt   <= i_tok_cnt + CW'(w_hit);
        r_tok_base  <= i_tok_base;
    end

    assign o_tok_vld   = r_tok_vld;
    assign o_tok_score = r_tok_score;
    assign o_tok_cnt   = r_tok_cnt;
    assign o_tok_base  = r_tok_base;
    assign o_flags     = r_flags;
    assign o_rank      = r_rank;

endmodule

/* hdl/stable_score_rank_core.sv */
// Top level of the stable score ranker: input control, cell chain and result register.
//
// Scores are taken one per cycle while a row is filling. Each accepted score
// becomes a token that walks the chain of cells, one cell per cycle: every
// occupied cell it passes compares against its stored score, bumps its own
// rank when a ranked newcomer is smaller, and adds one to the token's count of
// larger earlier scores; the first empty cell stores the token with rank
// (ranked count before it + 1 - larger count), so ties keep arrival order.
// Negative scores are stored unranked (rank 0). Scores past MAX_ENTRIES are
// dropped and flagged in the overflow field. The beat carrying last closes
// the row: input stalls while tokens still in flight settle, then the chain
// shifts toward cell 0 and one result beat per entry leaves at up to one per
// cycle, in arrival order, with final_res on the last. The unload empties
// the chain, so the next row starts clean. Row-wide fields (ranked_count,
// max_plus_one, max_index, overflow) are the same on every beat of a row.
module stable_score_rank_core #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [ssr_pkg::SCORE_W-1:0]  i_score,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [ssr_pkg::IDX_W-1:0]           o_entry_index,
    output logic [ssr_pkg::RANK_W-1:0]          o_rank,
    output logic                                o_ranked,
    output logic [ssr_pkg::RANK_W-1:0]          o_ranked_count,
    output logic [ssr_pkg::SCORE_W-1:0]         o_max_plus_one,
    output logic [ssr_pkg::IDX_W-1:0]           o_max_index,
    output logic                                o_overflow,
    output logic                                o_final_res
);

    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int SW  = ssr_pkg::SCORE_W;
    localparam int OIW = ssr_pkg::IDX_W;
    localparam int ORW = ssr_pkg::RANK_W;

    typedef enum logic [2:0] {
        ST_FILL  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_rank_cnt;
    logic signed [SW-1:0]   r_best;
    logic [IW-1:0]          r_best_idx;
    logic                   r_dropped;
    logic [CW-1:0]          r_emit_idx;

    // token entering cell 0
    logic                   r_tok_vld;
    logic signed [SW-1:0]   r_tok_score;
    logic [CW-1:0]          r_tok_base;

    // result register
    logic                   r_out_vld;
    logic [OIW-1:0]         r_out_idx;
    logic [ORW-1:0]         r_out_rank;
    logic                   r_out_ranked;
    logic [ORW-1:0]         r_out_rcnt;
    logic [SW-1:0]          r_out_mp1;
    logic [OIW-1:0]         r_out_midx;
    logic                   r_out_ovf;
    logic                   r_out_final;

    // chain links: token index k feeds cell k; flags and rank index k come from cell k
    logic                   w_tok_vld   [0:MAX_ENTRIES];
    logic signed [SW-1:0]   w_tok_score [0:MAX_ENTRIES];
    logic [CW-1:0]          w_tok_cnt   [0:MAX_ENTRIES];
    logic [CW-1:0]          w_tok_base  [0:MAX_ENTRIES];
    ssr_pkg::t_ssr_flags    w_flags     [0:MAX_ENTRIES];
    logic [CW-1:0]          w_rank      [0:MAX_ENTRIES];
    logic [MAX_ENTRIES:0]   w_busy;

    logic                   w_in_acc;
    logic                   w_room;
    logic                   w_load;
    logic                   w_shift;
    logic                   w_last_beat;

    assign o_ready  = (r_state == ST_FILL);
    assign w_in_acc = i_valid && o_ready;
    assign w_room   = (r_count < CW'(MAX_ENTRIES));

    // in the emit state, result register takes a beat when empty or being drained this cycle
    assign w_load      = (r_state == ST_EMIT) && (!r_out_vld || i_ready);
    assign w_shift     = w_load;
    assign w_last_beat = (r_emit_idx + CW'(1) == r_count);

    assign w_tok_vld[0]   = r_tok_vld;
    assign w_tok_score[0] = r_tok_score;
    assign w_tok_cnt[0]   = '0;
    assign w_tok_base[0]  = r_tok_base;
    assign w_flags[MAX_ENTRIES] = '0;
    assign w_rank[MAX_ENTRIES]  = '0;

    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        ssr_cell #(
            .CW (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_tok_vld   (w_tok_vld[k]),
            .i_tok_score (w_tok_score[k]),
            .i_tok_cnt   (w_tok_cnt[k]),
            .i_tok_base  (w_tok_base[k]),
            .o_tok_vld   (w_tok_vld[k+1]),
            .o_tok_score (w_tok_score[k+1]),
            .o_tok_cnt   (w_tok_cnt[k+1]),
            .o_tok_base  (w_tok_base[k+1]),
            .i_nb_flags  (w_flags[k+1]),
            .i_nb_rank   (w_rank[k+1]),
            .o_flags     (w_flags[k]),
            .o_rank      (w_rank[k])
        );
    end

    for (genvar k = 0; k <= MAX_ENTRIES; k++) begin : g_busy
        assign w_busy[k] = w_tok_vld[k];
    end

    // row control and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_count    <= '0;
            r_rank_cnt <= '0;
            r_best     <= -32'sd1;
            r_best_idx <= '0;
            r_dropped  <= 1'b0;
            r_emit_idx <= '0;
            r_tok_vld  <= 1'b0;
        end else begin
            r_tok_vld <= 1'b0;
            unique case (r_state)
                ST_FILL: begin
                    if (w_in_acc) begin
                        if (w_room) begin
                            r_tok_vld <= 1'b1;
                            r_count   <= r_count + CW'(1);
                            if (!i_score[SW-1]) begin
                                r_rank_cnt <= r_rank_cnt + CW'(1);
                            end
                            if (i_score > r_best) begin
                                r_best     <= i_score;
                                r_best_idx <= r_count[IW-1:0];
                            end
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (!(|w_busy)) begin
                        r_state    <= ST_EMIT;
                        r_emit_idx <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_load) begin
                        r_emit_idx <= r_emit_idx + CW'(1);
                        if (w_last_beat) begin
                            // row done: back to reset values
                            r_state    <= ST_FILL;
                            r_count    <= '0;
                            r_rank_cnt <= '0;
                            r_best     <= -32'sd1;
                            r_best_idx <= '0;
                            r_dropped  <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_FILL;
                end
            endcase
        end
    end

    // token payload for cell 0
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tok_score <= i_score;
            r_tok_base  <= r_rank_cnt + CW'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx    <= OIW'(r_emit_idx);
            r_out_rank   <= ORW'(w_rank[0]);
            r_out_ranked <= w_flags[0].ranked;
            r_out_rcnt   <= ORW'(r_rank_cnt);
            r_out_mp1    <= r_best + 32'sd1;
            r_out_midx   <= OIW'(r_best_idx);
            r_out_ovf    <= r_dropped;
            r_out_final  <= w_last_beat;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_entry_index  = r_out_idx;
    assign o_rank         = r_out_rank;
    assign o_ranked       = r_out_ranked;
    assign o_ranked_count = r_out_rcnt;
    assign o_max_plus_one = r_out_mp1;
    assign o_max_index    = r_out_midx;
    assign o_overflow     = r_out_ovf;
    assign o_final_res    = r_out_final;

endmodule
